/* rtl/core/three_wire_rtc_serial_master_macros.svh */
// assertion macros shared by the serial clock chip master
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_MACROS_SVH

// general property, checked outside reset
`define TWRSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same-cycle implication, checked outside reset
`define TWRSM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/twrsm_pkg.sv */
// types and constants of the three-wire serial clock chip master
package twrsm_pkg;

  localparam int unsigned BufferDepth = 32;

  localparam int unsigned OpcodeW = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 5;
  localparam int unsigned TickW   = 8;
  localparam int unsigned BitCntW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TickW-1:0]   HalfPeriodReset = TickW'(5);
  localparam logic [TickW-1:0]   EnableLowReset  = TickW'(50);
  localparam logic [BitCntW-1:0] LastBit         = '1;

  typedef enum logic [OpcodeW-1:0] {
    OpTick  = 2'd0,
    OpStart = 2'd1,
    OpLoad  = 2'd2,
    OpNop   = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHalfPeriod = 1'b0,
    CfgEnableLow  = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    PhIdle   = 6'b000001,
    PhCeLow  = 6'b000010,
    PhTxLow  = 6'b000100,
    PhTxHigh = 6'b001000,
    PhRxLow  = 6'b010000,
    PhRxHigh = 6'b100000
  } phase_e;

endpackage

/* rtl/core/twrsm_if.sv */
// channel interfaces of the three-wire serial clock chip master
interface twrsm_in_if;
  logic                           valid;
  logic                           ready;
  logic [twrsm_pkg::OpcodeW-1:0]  opcode;
  logic [twrsm_pkg::ByteW-1:0]    command_byte;
  logic [twrsm_pkg::CountW-1:0]   byte_count;
  logic [twrsm_pkg::ByteW-1:0]    write_data;
  logic                           io_in;

  modport source (output valid, opcode, command_byte, byte_count, write_data, io_in,
                  input ready);
  modport sink (input valid, opcode, command_byte, byte_count, write_data, io_in,
                output ready);
endinterface

interface twrsm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         chip_enable;
  logic                         serial_clock;
  logic                         io_out;
  logic                         io_drive;
  logic                         rx_valid;
  logic [twrsm_pkg::ByteW-1:0]  rx_byte;
  logic                         done_res;
  logic                         busy_res;

  modport source (output valid, chip_enable, serial_clock, io_out, io_drive, rx_valid,
                  rx_byte, done_res, busy_res, input ready);
  modport sink (input valid, chip_enable, serial_clock, io_out, io_drive, rx_valid,
                rx_byte, done_res, busy_res, output ready);
endinterface

interface twrsm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [twrsm_pkg::CfgIdxW-1:0] index;
  logic [twrsm_pkg::TickW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/twrsm_wbuf.sv */
// write byte buffer: one write port, one registered read port
module twrsm_wbuf #(
  parameter int unsigned Depth = twrsm_pkg::BufferDepth,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [AddrW-1:0]              wr_addr_i,
  input  logic [twrsm_pkg::ByteW-1:0]   wr_data_i,
  input  logic [AddrW-1:0]              rd_addr_i,
  output logic [twrsm_pkg::ByteW-1:0]   rd_data_o
);

  logic [twrsm_pkg::ByteW-1:0] mem_q [Depth];
  logic [twrsm_pkg::ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read address only moves when a byte is taken, well before the next one is needed
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/three_wire_rtc_serial_master.sv */
// top level of the three-wire serial clock chip master
// Pin-level master for a three-wire serial clock chip. Every input transaction (tick,
// start, load or nop) yields exactly one result transaction, shown in the cycle after
// its acceptance; a new input is accepted every cycle while the result register is empty
// or being drained, so the sustained rate is one transaction per clock. Time on the
// pins advances only with tick transactions: chip enable stays low for enable_low_ticks
// ticks, each bit spends half_period_ticks ticks with SCLK low and as many high, and a
// final low half period closes the transfer before done_res is raised. Load
// transactions fill the write buffer (BufferDepth bytes) while idle; starts and loads
// arriving while a transfer runs are dropped. Configuration writes complete at once.
`include "three_wire_rtc_serial_master_macros.svh"

module three_wire_rtc_serial_master #(
  parameter int unsigned BufferDepth = twrsm_pkg::BufferDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  twrsm_in_if.sink      in_i,
  twrsm_out_if.source   out_o,
  twrsm_cfg_if.sink     cfg_i
);

  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned FillW = $clog2(BufferDepth + 1);
  localparam int unsigned IdxW  = twrsm_pkg::CountW;
  localparam int unsigned ExtW  = (AddrW > IdxW) ? AddrW : IdxW;
  localparam int unsigned CmpW  = (FillW > IdxW) ? FillW : IdxW;
  localparam bit          DepthCovers = (BufferDepth >= (1 << IdxW));
  localparam logic [IdxW-1:0]  DepthLim  = IdxW'(BufferDepth);
  localparam logic [FillW-1:0] DepthFill = FillW'(BufferDepth);

  // configuration
  logic [twrsm_pkg::TickW-1:0] half_q, enable_low_q;

  // transfer state
  twrsm_pkg::phase_e             phase_q, phase_d;
  logic [twrsm_pkg::TickW-1:0]   tick_q, tick_d;
  logic [twrsm_pkg::BitCntW-1:0] bit_q, bit_d;
  logic [twrsm_pkg::CountW-1:0]  bytes_q, bytes_d;
  logic [twrsm_pkg::ByteW-1:0]   shift_q, shift_d;
  logic                          read_q, read_d;
  logic [FillW-1:0]              fill_q, fill_d;
  logic [IdxW-1:0]               idx_q, idx_d;

  // result register
  logic                          out_valid_q;
  logic                          ce_q, sclk_q, io_out_q, drive_q, rx_q, done_q, busy_q;
  logic [twrsm_pkg::ByteW-1:0]   rx_byte_q;

  logic                          in_ready, accept, start_take;
  logic                          rx_d, done_d, ce_d, sclk_d, drive_d;
  logic [twrsm_pkg::ByteW-1:0]   rx_byte_d, shift_rx, wr_byte, rd_data;
  logic                          wr_en, idx_valid;
  logic [ExtW-1:0]               idx_ext;
  logic [AddrW-1:0]              rd_addr, wr_addr;

  assign in_ready  = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign accept    = in_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q       <= twrsm_pkg::HalfPeriodReset;
      enable_low_q <= twrsm_pkg::EnableLowReset;
    end else if (cfg_i.valid) begin
      case (twrsm_pkg::cfg_reg_e'(cfg_i.index))
        twrsm_pkg::CfgHalfPeriod: half_q       <= cfg_i.data;
        twrsm_pkg::CfgEnableLow:  enable_low_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // buffer lookup for the next write byte; positions past the fill read as zero
  assign idx_ext   = ExtW'(idx_q);
  assign rd_addr   = idx_ext[AddrW-1:0];
  assign wr_addr   = fill_q[AddrW-1:0];
  assign idx_valid = (CmpW'(idx_q) < CmpW'(fill_q)) && (DepthCovers || (idx_q < DepthLim));
  assign wr_byte   = idx_valid ? rd_data : '0;
  assign shift_rx  = {in_i.io_in, shift_q[twrsm_pkg::ByteW-1:1]};

  twrsm_wbuf #(
    .Depth (BufferDepth),
    .AddrW (AddrW)
  ) u_wbuf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_i.write_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    bytes_d    = bytes_q;
    shift_d    = shift_q;
    read_d     = read_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    rx_d       = 1'b0;
    rx_byte_d  = '0;
    done_d     = 1'b0;
    wr_en      = 1'b0;
    start_take = 1'b0;
    if (accept) begin
      case (twrsm_pkg::opcode_e'(in_i.opcode))
        twrsm_pkg::OpTick: begin
          if (phase_q != twrsm_pkg::PhIdle) begin
            if (tick_q > twrsm_pkg::TickW'(1)) begin
              tick_d = tick_q - twrsm_pkg::TickW'(1);
            end else begin
              tick_d = half_q;
              case (phase_q)
                twrsm_pkg::PhCeLow: begin
                  bit_d   = '0;
                  phase_d = twrsm_pkg::PhTxLow;
                end
                twrsm_pkg::PhTxLow: begin
                  phase_d = twrsm_pkg::PhTxHigh;
                end
                twrsm_pkg::PhTxHigh: begin
                  if (bit_q != twrsm_pkg::LastBit) begin
                    bit_d   = bit_q + twrsm_pkg::BitCntW'(1);
                    shift_d = shift_q >> 1;
                    phase_d = twrsm_pkg::PhTxLow;
                  end else begin
                    bit_d = '0;
                    if (!read_q && (bytes_q != '0)) begin
                      bytes_d = bytes_q - twrsm_pkg::CountW'(1);
                      shift_d = wr_byte;
                      idx_d   = idx_q + IdxW'(1);
                      phase_d = twrsm_pkg::PhTxLow;
                    end else begin
                      shift_d = '0;
                      phase_d = twrsm_pkg::PhRxLow;
                    end
                  end
                end
                twrsm_pkg::PhRxLow: begin
                  if (bytes_q == '0) begin
                    // closing low half ends the transfer
                    if (!read_q) begin
                      fill_d = '0;
                    end
                    phase_d = twrsm_pkg::PhIdle;
                    tick_d  = '0;
                    bit_d   = '0;
                    done_d  = 1'b1;
                  end else begin
                    shift_d = shift_rx;
                    if (bit_q != twrsm_pkg::LastBit) begin
                      bit_d = bit_q + twrsm_pkg::BitCntW'(1);
                    end else begin
                      bit_d     = '0;
                      bytes_d   = bytes_q - twrsm_pkg::CountW'(1);
                      rx_d      = 1'b1;
                      rx_byte_d = shift_rx;
                    end
                    phase_d = twrsm_pkg::PhRxHigh;
                  end
                end
                twrsm_pkg::PhRxHigh: begin
                  phase_d = twrsm_pkg::PhRxLow;
                end
                default: begin
                  phase_d = twrsm_pkg::PhIdle;
                  tick_d  = '0;
                end
              endcase
            end
          end
        end
        twrsm_pkg::OpStart: begin
          if (phase_q == twrsm_pkg::PhIdle) begin
            start_take = 1'b1;
            shift_d    = in_i.command_byte;
            read_d     = in_i.command_byte[0];
            bytes_d    = in_i.byte_count;
            idx_d      = '0;
            bit_d      = '0;
            tick_d     = enable_low_q;
            phase_d    = twrsm_pkg::PhCeLow;
          end
        end
        twrsm_pkg::OpLoad: begin
          if ((phase_q == twrsm_pkg::PhIdle) && (fill_q < DepthFill)) begin
            wr_en  = 1'b1;
            fill_d = fill_q + FillW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ce_d    = (phase_d == twrsm_pkg::PhTxLow) || (phase_d == twrsm_pkg::PhTxHigh) ||
              (phase_d == twrsm_pkg::PhRxLow) || (phase_d == twrsm_pkg::PhRxHigh);
    sclk_d  = (phase_d == twrsm_pkg::PhTxHigh) || (phase_d == twrsm_pkg::PhRxHigh);
    drive_d = (phase_d == twrsm_pkg::PhTxLow) || (phase_d == twrsm_pkg::PhTxHigh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= twrsm_pkg::PhIdle;
      tick_q  <= '0;
      bit_q   <= '0;
      bytes_q <= '0;
      shift_q <= '0;
      read_q  <= 1'b0;
      fill_q  <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      bytes_q <= bytes_d;
      shift_q <= shift_d;
      read_q  <= read_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ce_q      <= ce_d;
      sclk_q    <= sclk_d;
      drive_q   <= drive_d;
      io_out_q  <= drive_d & shift_d[0];
      rx_q      <= rx_d;
      rx_byte_q <= rx_byte_d;
      done_q    <= done_d;
      busy_q    <= (phase_d != twrsm_pkg::PhIdle);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.chip_enable  = ce_q;
  assign out_o.serial_clock = sclk_q;
  assign out_o.io_out       = io_out_q;
  assign out_o.io_drive     = drive_q;
  assign out_o.rx_valid     = rx_q;
  assign out_o.rx_byte      = rx_byte_q;
  assign out_o.done_res     = done_q;
  assign out_o.busy_res     = busy_q;

  `TWRSM_ASSERT_IMP(ap_done_idle, clk_i, rst_ni, out_valid_q && done_q, !ce_q && !busy_q, "done shown while enable high or busy")
  `TWRSM_ASSERT_IMP(ap_rx_pins, clk_i, rst_ni, out_valid_q && rx_q, sclk_q && ce_q && !drive_q, "received byte outside a released high half")
  `TWRSM_ASSERT(ap_fill_bound, clk_i, rst_ni, (fill_q <= DepthFill), "buffer fill beyond depth")
  `TWRSM_ASSERT(ap_start_enters, clk_i, rst_ni, start_take |=> (phase_q == twrsm_pkg::PhCeLow), "start did not enter enable-low phase")

endmodule
